// ----- rtl/wtam_pkg.sv -----
// wtam_pkg: shared types and constants of the windowed tinted argb mapper
// used by the top level, wtam_front and wtam_back, depends on nothing
`default_nettype none

package wtam_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_MODE        = 3'd0;
	localparam logic [2:0] REG_WINDOW_LOW  = 3'd1;
	localparam logic [2:0] REG_WINDOW_HIGH = 3'd2;
	localparam logic [2:0] REG_WINDOW_GAIN = 3'd3;
	localparam logic [2:0] REG_TINT_RED    = 3'd4;
	localparam logic [2:0] REG_TINT_GREEN  = 3'd5;
	localparam logic [2:0] REG_TINT_BLUE   = 3'd6;

	// mode codes, the unused code behaves as tinted
	localparam logic [1:0] MODE_RAW  = 2'd0;
	localparam logic [1:0] MODE_GREY = 2'd1;
	localparam logic [1:0] MODE_TINT = 2'd2;

	// reset values
	localparam logic [31:0] WINDOW_LOW_RST  = 32'd0;
	localparam logic [31:0] WINDOW_HIGH_RST = 32'd255;
	localparam logic [31:0] WINDOW_GAIN_RST = 32'd16777216;
	localparam logic [16:0] TINT_RST        = 17'd65536;

	// fixed point constants
	localparam logic [7:0]  LEVEL_MAX  = 8'd255;
	localparam logic [31:0] LEVEL_TOP  = 32'hFF00_0000;   // 255 in q8.24
	localparam logic [31:0] LEVEL_HALF = 32'h0080_0000;   // half lsb of the level byte
	localparam logic [49:0] COLOR_HALF = 50'h00_8000_0000_00; // half lsb after >> 40

	// queue depths, powers of two
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		CLS_RAW,
		CLS_BELOW,
		CLS_ABOVE,
		CLS_INSIDE
	} cls_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] window_low;
		logic [31:0] window_high;
		logic [31:0] window_gain;
		logic [16:0] tint_red;
		logic [16:0] tint_green;
		logic [16:0] tint_blue;
	} cfg_t;

	// classified item between front and back, d holds the raw byte in raw mode
	typedef struct packed {
		cls_t        cls;
		logic        tinted;
		logic [31:0] d;
	} item_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
	} pixel_t;

endpackage

`default_nettype wire

// ----- rtl/windowed_tinted_argb_mapper_unit.sv -----
// windowed_tinted_argb_mapper_unit: top level, configuration registers and queues
// depends on wtam_pkg, wtam_queue, wtam_front and wtam_back
`default_nettype none

// Maps one signed grey sample to one premultiplied ARGB pixel. Push a sample
// while full is low; the pixel appears on blue/green/red/alpha while empty is
// low and leaves on pop. One sample per cycle is taken while full is low, and a
// transaction on the input side never waits on the result side while the
// internal queues have room. The front classifier is combinational and feeds a
// four entry item queue; the back pipeline (gain multiply, window saturation,
// tint multiplies with level rounding) rounds the colors on the way into the
// eight entry result queue. The back pipeline issues only when the result queue
// has a slot reserved for every item in flight. Configuration transactions are
// always taken (cfg_ready is high) and must be issued only while no sample is
// in flight. No clearing pass runs after reset.
module windowed_tinted_argb_mapper_unit #(
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// sample side
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] sample,
	// pixel side
	output logic             empty,
	input  wire logic        pop,
	output logic [7:0]       blue,
	output logic [7:0]       green,
	output logic [7:0]       red,
	output logic [7:0]       alpha,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	wtam_pkg::cfg_t   cfg_q;
	wtam_pkg::item_t  front_item;
	wtam_pkg::item_t  mid_item;
	wtam_pkg::pixel_t back_pixel;
	wtam_pkg::pixel_t out_pixel;

	logic                             mid_full;
	logic                             mid_empty;
	logic                             mid_pop;
	logic [$clog2(wtam_pkg::MID_DEPTH+1)-1:0] mid_count;
	logic                             out_push;
	logic                             out_full;
	logic [wtam_pkg::OUT_CNT_W-1:0]   out_count;
	logic                             mid_push;

	// configuration registers, one write transaction per cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode        <= wtam_pkg::MODE_RAW;
			cfg_q.window_low  <= wtam_pkg::WINDOW_LOW_RST;
			cfg_q.window_high <= wtam_pkg::WINDOW_HIGH_RST;
			cfg_q.window_gain <= wtam_pkg::WINDOW_GAIN_RST;
			cfg_q.tint_red    <= wtam_pkg::TINT_RST;
			cfg_q.tint_green  <= wtam_pkg::TINT_RST;
			cfg_q.tint_blue   <= wtam_pkg::TINT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wtam_pkg::REG_MODE:        cfg_q.mode        <= cfg_data[1:0];
				wtam_pkg::REG_WINDOW_LOW:  cfg_q.window_low  <= cfg_data;
				wtam_pkg::REG_WINDOW_HIGH: cfg_q.window_high <= cfg_data;
				wtam_pkg::REG_WINDOW_GAIN: cfg_q.window_gain <= cfg_data;
				wtam_pkg::REG_TINT_RED:    cfg_q.tint_red    <= cfg_data[16:0];
				wtam_pkg::REG_TINT_GREEN:  cfg_q.tint_green  <= cfg_data[16:0];
				wtam_pkg::REG_TINT_BLUE:   cfg_q.tint_blue   <= cfg_data[16:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// front: classify the sample in the cycle it is pushed
	wtam_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.sample (sample),
		.cfg    (cfg_q),
		.item   (front_item)
	);

	assign full     = mid_full;
	assign mid_push = push && !mid_full;

	// item queue decouples the front from the back pipeline
	wtam_queue #(
		.WIDTH ($bits(wtam_pkg::item_t)),
		.DEPTH (wtam_pkg::MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (front_item),
		.rd_en   (mid_pop),
		.rd_data (mid_item),
		.full    (mid_full),
		.empty   (mid_empty),
		.count   (mid_count)
	);

	// back: scale, tint and round
	wtam_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item       (mid_item),
		.item_empty (mid_empty),
		.item_pop   (mid_pop),
		.out_count  (out_count),
		.out_push   (out_push),
		.out_pixel  (back_pixel)
	);

	// result queue, the oldest pixel sits on the ports
	wtam_queue #(
		.WIDTH ($bits(wtam_pkg::pixel_t)),
		.DEPTH (wtam_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (back_pixel),
		.rd_en   (pop),
		.rd_data (out_pixel),
		.full    (out_full),
		.empty   (empty),
		.count   (out_count)
	);

	assign blue  = out_pixel.blue;
	assign green = out_pixel.green;
	assign red   = out_pixel.red;
	assign alpha = out_pixel.alpha;

	// the reservation in the back pipeline must keep the result queue from overflowing
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue written while full");

	// the back pipeline only issues from a nonempty item queue
	a_mid_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> (mid_count != '0))
		else $error("item queue popped while empty");

endmodule

`default_nettype wire

// ----- rtl/wtam_queue.sv -----
// wtam_queue: small first-in first-out queue with occupancy count
// generic storage, depends on nothing
`default_nettype none

module wtam_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	output logic      [WIDTH-1:0]           rd_data,
	output logic                            full,
	output logic                            empty,
	output logic      [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wtam_front.sv -----
// wtam_front: sign extends a sample and classifies it against the window
// depends on wtam_pkg
`default_nettype none

module wtam_front #(
	parameter int SAMPLE_BITS = 32
) (
	input  wire logic [31:0]        sample,
	input  wire wtam_pkg::cfg_t     cfg,
	output wtam_pkg::item_t         item
);

	logic signed [32:0] s_ext;
	logic signed [32:0] low_ext;
	logic signed [32:0] high_ext;
	logic        [32:0] diff;
	logic        [7:0]  raw_byte;

	always_comb begin
		s_ext    = signed'({{(33 - SAMPLE_BITS){sample[SAMPLE_BITS-1]}},
			sample[SAMPLE_BITS-1:0]});
		low_ext  = signed'({cfg.window_low[31], cfg.window_low});
		high_ext = signed'({cfg.window_high[31], cfg.window_high});
		diff     = 33'(s_ext - low_ext);

		// raw mode clamps to a byte
		if (s_ext < 33'sd0) begin
			raw_byte = '0;
		end else if (s_ext > 33'sd255) begin
			raw_byte = wtam_pkg::LEVEL_MAX;
		end else begin
			raw_byte = s_ext[7:0];
		end

		item.tinted = (cfg.mode != wtam_pkg::MODE_RAW) && (cfg.mode != wtam_pkg::MODE_GREY);
		item.d      = diff[31:0];
		if (cfg.mode == wtam_pkg::MODE_RAW) begin
			item.cls = wtam_pkg::CLS_RAW;
			item.d   = {24'd0, raw_byte};
		end else if (s_ext < low_ext) begin
			item.cls = wtam_pkg::CLS_BELOW;
		end else if (s_ext > high_ext) begin
			item.cls = wtam_pkg::CLS_ABOVE;
		end else begin
			item.cls = wtam_pkg::CLS_INSIDE;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/wtam_back.sv -----
// wtam_back: three stage scale, tint and round pipeline behind the item queue
// depends on wtam_pkg, reserves room in the result queue before issuing
`default_nettype none

module wtam_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire wtam_pkg::cfg_t                     cfg,
	input  wire wtam_pkg::item_t                    item,
	input  wire logic                               item_empty,
	output logic                                    item_pop,
	input  wire logic [wtam_pkg::OUT_CNT_W-1:0]     out_count,
	output logic                                    out_push,
	output wtam_pkg::pixel_t                        out_pixel
);

	function automatic logic [7:0] round_color(input logic [48:0] prod);
		logic [49:0] sum;
		sum = {1'b0, prod} + wtam_pkg::COLOR_HALF;
		round_color = (sum[49:40] > 10'd255) ? wtam_pkg::LEVEL_MAX : sum[47:40];
	endfunction

	logic                       valid_s1, valid_s2, valid_s3;
	wtam_pkg::cls_t             cls_s1, cls_s2, cls_s3;
	logic                       tinted_s1, tinted_s2, tinted_s3;
	logic [7:0]                 raw_s1, raw_s2, raw_s3;
	logic [63:0]                prod_s1;
	logic [31:0]                t_s2;
	logic [7:0]                 level_s3;
	logic [48:0]                red_s3, green_s3, blue_s3;

	logic [wtam_pkg::OUT_CNT_W:0] credit;
	logic [31:0]                  t_next;
	logic [31:0]                  level_sum;
	logic [7:0]                   grey;

	// items in flight plus results waiting must fit in the result queue
	always_comb begin
		credit   = {1'b0, out_count} + (wtam_pkg::OUT_CNT_W + 1)'(valid_s1)
			+ (wtam_pkg::OUT_CNT_W + 1)'(valid_s2) + (wtam_pkg::OUT_CNT_W + 1)'(valid_s3);
		item_pop = !item_empty && (credit < (wtam_pkg::OUT_CNT_W + 1)'(wtam_pkg::OUT_DEPTH));
	end

	always_comb begin
		unique case (cls_s1)
			wtam_pkg::CLS_BELOW: t_next = '0;
			wtam_pkg::CLS_ABOVE: t_next = wtam_pkg::LEVEL_TOP;
			default: begin
				t_next = (prod_s1 > {32'd0, wtam_pkg::LEVEL_TOP}) ? wtam_pkg::LEVEL_TOP
					: prod_s1[31:0];
			end
		endcase
		level_sum = t_s2 + wtam_pkg::LEVEL_HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= item_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1    <= item.cls;
		tinted_s1 <= item.tinted;
		raw_s1    <= item.d[7:0];
		prod_s1   <= 64'(item.d) * 64'(cfg.window_gain);

		cls_s2    <= cls_s1;
		tinted_s2 <= tinted_s1;
		raw_s2    <= raw_s1;
		t_s2      <= t_next;

		cls_s3    <= cls_s2;
		tinted_s3 <= tinted_s2;
		raw_s3    <= raw_s2;
		level_s3  <= level_sum[31:24];
		red_s3    <= 49'(t_s2) * 49'(cfg.tint_red);
		green_s3  <= 49'(t_s2) * 49'(cfg.tint_green);
		blue_s3   <= 49'(t_s2) * 49'(cfg.tint_blue);
	end

	always_comb begin
		out_push = valid_s3;
		grey     = (cls_s3 == wtam_pkg::CLS_RAW) ? raw_s3 : level_s3;
		if (tinted_s3 && cls_s3 != wtam_pkg::CLS_RAW) begin
			out_pixel.blue  = round_color(blue_s3);
			out_pixel.green = round_color(green_s3);
			out_pixel.red   = round_color(red_s3);
			out_pixel.alpha = level_s3;
		end else begin
			out_pixel.blue  = grey;
			out_pixel.green = grey;
			out_pixel.red   = grey;
			out_pixel.alpha = wtam_pkg::LEVEL_MAX;
		end
	end

	a_grey_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !tinted_s3) |-> (out_pixel.blue == out_pixel.green
			&& out_pixel.green == out_pixel.red && out_pixel.alpha == wtam_pkg::LEVEL_MAX))
		else $error("grey result with unequal bytes");

	a_above_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && cls_s3 == wtam_pkg::CLS_ABOVE) |-> (level_s3 == wtam_pkg::LEVEL_MAX))
		else $error("sample above window did not give full level");

endmodule

`default_nettype wire
